// File: design/nrp_pkg.sv
// shared types and constants for the rmc position parser
`default_nettype none
package nrp_pkg;

  localparam logic [2:0] OC_NOT_RMC   = 3'd0;
  localparam logic [2:0] OC_BAD_CSUM  = 3'd1;
  localparam logic [2:0] OC_FEW_FLDS  = 3'd2;
  localparam logic [2:0] OC_VOID     = 3'd3;
  localparam logic [2:0] OC_BAD_COORD = 3'd4;
  localparam logic [2:0] OC_FIX      = 3'd5;

  localparam int unsigned INT_SAT = 99999;
  localparam int unsigned POS_W   = 35;

  // one finished line handed from the front to the back
  typedef struct packed {
    logic [2:0]  outcome;
    logic [16:0] lat_int;
    logic [23:0] lat_frac;   // fraction scaled to full digit count
    logic        lat_neg;
    logic [16:0] lon_int;
    logic [23:0] lon_frac;
    logic        lon_neg;
  } line_t;

endpackage
`default_nettype wire

// File: design/nmea_rmc_position_parser.sv
// top level of the rmc sentence position parser
// result path: a newline word's result passes the front line register, the queue, three
// conversion stages and the output register once it is accepted; other words give no result
// throughput: one input word per cycle, set by the per-character front, unless a full queue holds its line summary
// reset: synchronous rst clears line state, stored fix and all valid flags
`default_nettype none
module nmea_rmc_position_parser import nrp_pkg::*; #(
  parameter int LINE_BUFFER_BYTES = 128,
  parameter int FRACTION_DIGITS   = 5
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // rx_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [79:0]      m_tdata    // outcome, fix_valid, latitude_e7, longitude_e7
);
  line_t f_line, q_line;
  logic  f_v, f_r, q_v, q_r;
  logic [2:0] oc;
  logic fv;
  logic signed [POS_W-1:0] lat, lon;

  // front: parses characters, one per cycle unless a full queue holds its line summary
  nrp_front #(.LINE_BUFFER_BYTES(LINE_BUFFER_BYTES), .FRACTION_DIGITS(FRACTION_DIGITS))
    u_front (.clk, .rst, .in_valid(s_tvalid), .in_ready(s_tready), .in_byte(s_tdata),
             .line_valid(f_v), .line_ready(f_r), .line(f_line));

  // decoupling queue of finished lines
  nrp_queue u_queue (.clk, .rst, .wr_valid(f_v), .wr_ready(f_r), .wr_data(f_line),
                     .rd_valid(q_v), .rd_ready(q_r), .rd_data(q_line));

  // back: coordinate conversion and fix storage
  nrp_back #(.FRACTION_DIGITS(FRACTION_DIGITS))
    u_back (.clk, .rst, .in_valid(q_v), .in_ready(q_r), .in_line(q_line),
            .out_valid(m_tvalid), .out_ready(m_tready), .out_outcome(oc),
            .out_fix_valid(fv), .out_lat(lat), .out_lon(lon));

  assign m_tdata = {6'd0, lon, lat, fv, oc};
endmodule
`default_nettype wire

// File: design/nrp_front.sv
// front part: per-character line parsing, emits one line summary at newline
`default_nettype none
module nrp_front import nrp_pkg::*; #(
  parameter int LINE_BUFFER_BYTES = 128,
  parameter int FRACTION_DIGITS   = 5
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  output logic            line_valid,
  input  wire logic       line_ready,
  output line_t           line
);
  localparam int CW = $clog2(LINE_BUFFER_BYTES);
  localparam int FW = 24;
  localparam int NW = $clog2(FRACTION_DIGITS + 1);

  logic [CW-1:0] char_count;
  logic [6:0]    field_number;
  logic [1:0]    header_match;
  logic [7:0]    running_xor, xor_at_last_star, given_checksum, status_char;
  logic          star_seen, hex_active, field_fresh;
  logic [16:0]   coord_integer [2];
  logic [FW-1:0] coord_fraction [2];
  logic [NW-1:0] frac_count [2];
  logic          f_ne [2], f_neg [2], f_frac [2], f_stop [2], f_hemi [2];

  assign in_ready = !line_valid || line_ready;
  wire take = in_valid && in_ready;
  wire nl   = in_byte == 8'h0A;
  wire [7:0] c = in_byte;
  wire is_dig = c >= "0" && c <= "9";
  wire [3:0] dig = c[3:0];

  logic [4:0] hv; // bit4 = valid
  always_comb begin
    if (is_dig) hv = {1'b1, dig};
    else if (c >= "A" && c <= "F") hv = {1'b1, 4'(c - 8'd55)};
    else if (c >= "a" && c <= "f") hv = {1'b1, 4'(c - 8'd87)};
    else hv = 5'd0;
  end

  // fraction scaled up to FRACTION_DIGITS digits
  function automatic logic [FW-1:0] scale_frac(logic [FW-1:0] f, logic [NW-1:0] n);
    logic [FW-1:0] r;
    r = f;
    for (int i = 0; i < 7; i++)
      if (i < FRACTION_DIGITS && NW'(i) >= n) r = FW'(r * 10);
    return r;
  endfunction

  logic [2:0] oc;
  always_comb begin
    if (char_count < CW'(6) || header_match == 2'b00) oc = OC_NOT_RMC;
    else if (!star_seen || xor_at_last_star != given_checksum) oc = OC_BAD_CSUM;
    else if (field_number < 7'd6) oc = OC_FEW_FLDS;
    else if (status_char != "A") oc = OC_VOID;
    else if (!f_ne[0] || !f_ne[1]) oc = OC_BAD_COORD;
    else oc = OC_FIX;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_valid <= 1'b0;
    end else if (take && nl) begin
      line_valid <= 1'b1;
    end else if (line_ready) begin
      line_valid <= 1'b0;
    end
    if (take && nl) begin
      line.outcome  <= oc;
      line.lat_int  <= coord_integer[0];
      line.lat_frac <= scale_frac(coord_fraction[0], frac_count[0]);
      line.lat_neg  <= f_neg[0] ^ f_hemi[0];
      line.lon_int  <= coord_integer[1];
      line.lon_frac <= scale_frac(coord_fraction[1], frac_count[1]);
      line.lon_neg  <= f_neg[1] ^ f_hemi[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (take && nl)) begin
      char_count <= '0; field_number <= '0; header_match <= 2'b11;
      running_xor <= '0; xor_at_last_star <= '0; star_seen <= 1'b0;
      given_checksum <= '0; hex_active <= 1'b0; field_fresh <= 1'b1;
      status_char <= '0;
      for (int k = 0; k < 2; k++) begin
        coord_integer[k] <= '0; coord_fraction[k] <= '0; frac_count[k] <= '0;
        f_ne[k] <= 1'b0; f_neg[k] <= 1'b0; f_frac[k] <= 1'b0;
        f_stop[k] <= 1'b0; f_hemi[k] <= 1'b0;
      end
    end else if (take && char_count < CW'(LINE_BUFFER_BYTES - 1)) begin
      char_count <= char_count + 1'b1;
      unique case (char_count)
        CW'(0): if (c != "$") header_match <= 2'b00;
        CW'(1): if (c != "G") header_match <= 2'b00;
        CW'(2): header_match <= header_match & {c == "N", c == "P"};
        CW'(3): if (c != "R") header_match <= 2'b00;
        CW'(4): if (c != "M") header_match <= 2'b00;
        CW'(5): if (c != "C") header_match <= 2'b00;
        default: ;
      endcase
      if (char_count != '0) begin
        running_xor <= running_xor ^ c;
        if (c == "*") begin
          xor_at_last_star <= running_xor; star_seen <= 1'b1;
          given_checksum <= '0; hex_active <= 1'b1;
        end else if (hex_active) begin
          if (hv[4]) given_checksum <= {given_checksum[3:0], hv[3:0]};
          else hex_active <= 1'b0;
        end
      end
      if (c == ",") begin
        if (field_number != 7'd127) field_number <= field_number + 1'b1;
        field_fresh <= 1'b1;
      end else begin
        field_fresh <= 1'b0;
        for (int k = 0; k < 2; k++) begin
          if (field_number == 7'(3 + 2 * k)) begin
            f_ne[k] <= 1'b1;
            if (!f_stop[k]) begin
              if (field_fresh && (c == "-" || c == "+")) begin
                if (c == "-") f_neg[k] <= 1'b1;
              end else if (is_dig) begin
                if (f_frac[k]) begin
                  if (frac_count[k] < NW'(FRACTION_DIGITS)) begin
                    coord_fraction[k] <= FW'(coord_fraction[k] * 10 + dig);
                    frac_count[k] <= frac_count[k] + 1'b1;
                  end
                end else begin
                  coord_integer[k] <= (21'(coord_integer[k]) * 10 + 21'(dig) > 21'(INT_SAT))
                    ? 17'(INT_SAT) : 17'(21'(coord_integer[k]) * 10 + 21'(dig));
                end
              end else if (c == "." && !f_frac[k]) begin
                f_frac[k] <= 1'b1;
              end else begin
                f_stop[k] <= 1'b1;
              end
            end
          end
          if (field_number == 7'(4 + 2 * k) && field_fresh && (c == "S" || c == "W"))
            f_hemi[k] <= 1'b1;
        end
        if (field_number == 7'd2 && field_fresh) status_char <= c;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) line_valid && !line_ready |=> $stable(line))
    else $error("line summary changed while held");
  assert property (@(posedge clk) disable iff (rst) take && nl |=> char_count == '0)
    else $error("line state not cleared at newline");
  assert property (@(posedge clk) disable iff (rst) header_match != 2'b11 || char_count < CW'(3))
    else $error("header variant unresolved past third char");
endmodule
`default_nettype wire

// File: design/nrp_queue.sv
// two-entry queue between front and back
`default_nettype none
module nrp_queue import nrp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_valid,
  output logic      wr_ready,
  input  line_t     wr_data,
  output logic      rd_valid,
  input  wire logic rd_ready,
  output line_t     rd_data
);
  line_t      mem [2];
  logic       wp, rp;
  logic [1:0] cnt;
  wire wr = wr_valid && wr_ready;
  wire rd = rd_valid && rd_ready;
  assign wr_ready = cnt != 2'd2;
  assign rd_valid = cnt != 2'd0;
  assign rd_data  = mem[rp];
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= '0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      cnt <= cnt + 2'(wr) - 2'(rd);
    end
    if (wr) mem[wp] <= wr_data;
  end
  assert property (@(posedge clk) disable iff (rst) cnt <= 2'd2)
    else $error("queue overflow");
endmodule
`default_nettype wire

// File: design/nrp_back.sv
// back part: converts coordinates over pipeline stages, holds stored fix, output register
`default_nettype none
module nrp_back import nrp_pkg::*; #(
  parameter int FRACTION_DIGITS = 5
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  line_t                  in_line,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [2:0]             out_outcome,
  output logic                   out_fix_valid,
  output logic signed [POS_W-1:0] out_lat,
  output logic signed [POS_W-1:0] out_lon
);
  localparam longint P10R  = 10 ** (7 - FRACTION_DIGITS);
  // reciprocal of 100 for integer parts below 2^17: d = (ip * RCP100) >> 24
  localparam longint RCP100 = (64'd1 << 24) / 100 + 1;
  // reciprocal of 60 for minutes below 1e9: q = (m * RCP60) >> 38
  localparam longint RCP60  = (64'd1 << 38) / 60 + 1;

  // stage 1: degrees split off the integer part
  // stage 2: minutes scaled to 10^7
  // stage 3: degrees plus minutes / 60
  logic        s1_v, s2_v, s3_v;
  logic [2:0]  s1_oc, s2_oc, s3_oc;
  logic [16:0] s1_ip [2];
  logic [23:0] s1_fr [2];
  logic [16:0] s1_deg [2], s2_deg [2];
  logic [29:0] s2_min [2];
  logic        s1_neg [2], s2_neg [2], s3_neg [2];
  logic [33:0] s3_mag [2];
  logic [POS_W-1:0] st_pos [2];
  logic        st_valid;

  wire adv = !out_valid || out_ready;
  assign in_ready = adv;

  function automatic logic [16:0] div100(logic [16:0] ip);
    return 17'((longint'(ip) * RCP100) >> 24);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0; s2_v <= 1'b0; s3_v <= 1'b0; out_valid <= 1'b0; st_valid <= 1'b0;
      st_pos[0] <= '0; st_pos[1] <= '0;
    end else if (adv) begin
      s1_v <= in_valid;
      s2_v <= s1_v;
      s3_v <= s2_v;
      out_valid <= s3_v;
      if (s3_v) begin
        if (s3_oc == OC_VOID) st_valid <= 1'b0;
        if (s3_oc == OC_FIX) st_valid <= 1'b1;
      end
      if (s3_v && s3_oc == OC_FIX)
        for (int k = 0; k < 2; k++)
          st_pos[k] <= s3_neg[k] ? POS_W'(-{1'b0, s3_mag[k]}) : POS_W'(s3_mag[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_oc <= in_line.outcome;
      s1_ip[0] <= in_line.lat_int;
      s1_ip[1] <= in_line.lon_int;
      s1_fr[0] <= in_line.lat_frac;
      s1_fr[1] <= in_line.lon_frac;
      s1_deg[0] <= div100(in_line.lat_int);
      s1_deg[1] <= div100(in_line.lon_int);
      s1_neg[0] <= in_line.lat_neg;
      s1_neg[1] <= in_line.lon_neg;
      s2_oc <= s1_oc;
      s3_oc <= s2_oc;
      for (int k = 0; k < 2; k++) begin
        s2_neg[k] <= s1_neg[k];
        s2_deg[k] <= s1_deg[k];
        // (ip % 100) * 10^7 + fraction * 10^(7-fd), rem taken as ip - deg * 100
        s2_min[k] <= 30'(longint'(s1_ip[k]) * 10000000 + longint'(s1_fr[k]) * P10R
                    - longint'(s1_deg[k]) * 1000000000);
        s3_neg[k] <= s2_neg[k];
        s3_mag[k] <= 34'(longint'(s2_deg[k]) * 10000000
                    + ((longint'(s2_min[k]) * RCP60) >>> 38));
      end
    end
  end

  assign out_fix_valid = st_valid;
  assign out_lat = st_pos[0];
  assign out_lon = st_pos[1];
  always_ff @(posedge clk) if (adv) out_outcome <= s3_oc;

  assert property (@(posedge clk) disable iff (rst)
      out_valid && !out_ready |=> out_valid && $stable(out_outcome))
    else $error("result dropped while stalled");
endmodule
`default_nettype wire

// File: dv/nmea_rmc_position_parser_test.sv
// testbench for the rmc sentence position parser: directed lines and random sentences
`timescale 1ns / 1ps
`default_nettype none
module nmea_rmc_position_parser_test;
  import nrp_pkg::*;

  localparam int LINE_MAX   = 127;
  localparam int FRAC_DIGS  = 5;
  localparam int STALL_MAX  = 8000;
  localparam int RAND_LINES = 10;

  // one parse result as it leaves the block
  typedef struct {
    logic [2:0]  outcome;
    logic        fix_valid;
    logic [34:0] lat_e7;
    logic [34:0] lon_e7;
  } fix_rec_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // rx_byte
  logic        m_tvalid;
  logic        m_tready;
  logic [79:0] m_tdata;   // outcome, fix_valid, latitude_e7, longitude_e7

  nmea_rmc_position_parser dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // parser state mirrored per line
  int unsigned n_chars, n_fields, hdr_ok, xor_run, xor_star, star_hit, csum_given;
  int unsigned hex_on, fresh, status_ch;
  int unsigned c_int[2], c_frac[2], c_flags[2], c_fcnt[2];
  logic [34:0] fix_pos[2];
  logic        fix_ok;

  fix_rec_t fix_queue[$];
  int       errors;
  int       lines_left_rand;
  bit       hold_rx;      // long receiver stall request
  bit       done_tx;

  localparam int FL_NONEMPTY = 1, FL_NEG = 2, FL_FRAC = 4, FL_STOP = 8, FL_HEMI = 16;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  function automatic void line_clear();
    n_chars = 0; n_fields = 0; hdr_ok = 3; xor_run = 0; xor_star = 0; star_hit = 0;
    csum_given = 0; hex_on = 0; fresh = 1; status_ch = 0;
    for (int k = 0; k < 2; k++) begin
      c_int[k] = 0; c_frac[k] = 0; c_flags[k] = 0; c_fcnt[k] = 0;
    end
  endfunction

  function automatic int hex_of(input int unsigned c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "A" && c <= "F") return c - "A" + 10;
    if (c >= "a" && c <= "f") return c - "a" + 10;
    return -1;
  endfunction

  function automatic void coord_digit(input int k, input int unsigned c, input bit first);
    int unsigned fl, v;
    fl = c_flags[k] | FL_NONEMPTY;
    if (!(fl & FL_STOP)) begin
      if (first && (c == "-" || c == "+")) begin
        if (c == "-") fl |= FL_NEG;
      end else if (c >= "0" && c <= "9") begin
        if (fl & FL_FRAC) begin
          if (c_fcnt[k] < FRAC_DIGS) begin
            c_frac[k] = c_frac[k] * 10 + (c - "0");
            c_fcnt[k]++;
          end
        end else begin
          v = c_int[k] * 10 + (c - "0");
          c_int[k] = (v > INT_SAT) ? INT_SAT : v;
        end
      end else if (c == "." && !(fl & FL_FRAC)) begin
        fl |= FL_FRAC;
      end else begin
        fl |= FL_STOP;
      end
    end
    c_flags[k] = fl;
  endfunction

  function automatic void parse_char(input int unsigned c);
    int h;
    bit first;
    if (n_chars < 6) begin
      case (n_chars)
        0: if (c != "$") hdr_ok = 0;
        1: if (c != "G") hdr_ok = 0;
        2: begin
          if (c != "P") hdr_ok &= ~1;
          if (c != "N") hdr_ok &= ~2;
        end
        3: if (c != "R") hdr_ok = 0;
        4: if (c != "M") hdr_ok = 0;
        default: if (c != "C") hdr_ok = 0;
      endcase
    end
    if (n_chars >= 1) begin
      if (c == "*") begin
        xor_star = xor_run; star_hit = 1; csum_given = 0; hex_on = 1;
      end else if (hex_on) begin
        h = hex_of(c);
        if (h >= 0) csum_given = ((csum_given << 4) | h) & 8'hff;
        else hex_on = 0;
      end
      xor_run ^= c;
    end
    if (c == ",") begin
      if (n_fields < 127) n_fields++;
      fresh = 1;
      return;
    end
    first = fresh;
    fresh = 0;
    case (n_fields)
      2: if (first) status_ch = c;
      3: coord_digit(0, c, first);
      5: coord_digit(1, c, first);
      4, 6: if (first && (c == "S" || c == "W")) c_flags[(n_fields - 4) >> 1] |= FL_HEMI;
      default: ;
    endcase
  endfunction

  function automatic logic [34:0] degrees_e7(input int k);
    longint unsigned ip, fr, mins, mag;
    bit neg;
    ip = c_int[k];
    fr = longint'(c_frac[k]) * (10 ** (FRAC_DIGS - c_fcnt[k]));
    mins = (ip % 100) * (10 ** FRAC_DIGS) + fr;
    mag = (ip / 100) * 10000000 + mins * (10 ** (7 - FRAC_DIGS)) / 60;
    neg = ((c_flags[k] & FL_NEG) != 0) != ((c_flags[k] & FL_HEMI) != 0);
    return neg ? 35'(-mag) : 35'(mag);
  endfunction

  function automatic logic [2:0] close_line();
    if (n_chars < 6 || hdr_ok == 0) return OC_NOT_RMC;
    if (!star_hit || xor_star != csum_given) return OC_BAD_CSUM;
    if (n_fields + 1 < 7) return OC_FEW_FLDS;
    if (status_ch != "A") begin
      fix_ok = 1'b0;
      return OC_VOID;
    end
    if (!(c_flags[0] & FL_NONEMPTY) || !(c_flags[1] & FL_NONEMPTY)) return OC_BAD_COORD;
    fix_pos[0] = degrees_e7(0);
    fix_pos[1] = degrees_e7(1);
    fix_ok = 1'b1;
    return OC_FIX;
  endfunction

  // advance the model by one accepted word, queue the fix record on newline
  function automatic void predict_word(input logic [7:0] c);
    fix_rec_t r;
    if (c == 8'h0a) begin
      r.outcome = close_line();
      line_clear();
      r.fix_valid = fix_ok;
      r.lat_e7 = fix_pos[0];
      r.lon_e7 = fix_pos[1];
      fix_queue.push_back(r);
    end else if (n_chars < LINE_MAX) begin
      parse_char(c);
      n_chars++;
    end
  endfunction

  // stimulus byte stream built line by line
  byte unsigned tx_bytes[$];

  function automatic void add_str(input string s);
    for (int i = 0; i < s.len(); i++) tx_bytes.push_back(s[i]);
  endfunction

  function automatic string hex2(input int unsigned v);
    return $sformatf("%02X", v & 8'hff);
  endfunction

  function automatic int unsigned body_xor(input string s);
    int unsigned x = 0;
    for (int i = 1; i < s.len(); i++) x ^= s[i];
    return x;
  endfunction

  // add "body*CS\n" with correct or corrupted checksum
  function automatic void add_sentence(input string body, input bit good);
    int unsigned x;
    x = body_xor(body);
    if (!good) x ^= (1 << $urandom_range(0, 7));
    add_str({body, "*", ($urandom_range(0, 1) ? hex2(x) : $sformatf("%02x", x)), "\n"});
  endfunction

  function automatic string rand_coord(input int ideg);
    string s;
    s = "";
    case ($urandom_range(0, 9))
      0: s = "-";
      1: s = "+";
      default: ;
    endcase
    s = {s, $sformatf("%0d%02d", $urandom_range(0, ideg), $urandom_range(0, 99))};
    if ($urandom_range(0, 5) != 0) begin
      s = {s, "."};
      repeat ($urandom_range(0, 7)) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
    end
    if ($urandom_range(0, 15) == 0) s = {s, "x9"};
    return s;
  endfunction

  function automatic string rand_rmc();
    string s, st;
    case ($urandom_range(0, 9))
      0: st = "V";
      1: st = "";
      default: st = "A";
    endcase
    s = {($urandom_range(0, 1) ? "$GPRMC" : "$GNRMC"), ",123519.00,", st, ","};
    s = {s, ($urandom_range(0, 15) == 0) ? "" : rand_coord(90), ",",
         ($urandom_range(0, 1) ? "N" : "S"), ","};
    s = {s, ($urandom_range(0, 15) == 0) ? "" : rand_coord(180), ",",
         ($urandom_range(0, 1) ? "E" : "W")};
    if ($urandom_range(0, 1)) s = {s, ",0.5,54.7,191194,,"};
    return s;
  endfunction

  function automatic void add_noise_line();
    int n;
    n = $urandom_range(0, 40);
    for (int i = 0; i < n; i++) begin
      byte unsigned b;
      b = $urandom_range(0, 255);
      if (b == 8'h0a) b = 8'h0d;
      tx_bytes.push_back(b);
    end
    tx_bytes.push_back(8'h0a);
  endfunction

  // directed rows: line text and, where obvious, the expected outcome (-1: predictor only)
  typedef struct {
    string text;
    int    outcome;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic void add_row(input string s, input int oc);
    dir_row_t r;
    r.text = s; r.outcome = oc;
    dir_rows.push_back(r);
  endfunction

  // sender: random gaps, one nonblocking drive per edge
  task automatic send_byte(input byte unsigned b);
    int gap;
    gap = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_word(b);
  endtask

  task automatic send_all();
    while (tx_bytes.size() > 0) send_byte(tx_bytes.pop_front());
    s_tvalid <= 1'b0;
  endtask

  string long_line;
  logic [2:0] want_code;

  initial begin
    errors = 0; done_tx = 0; hold_rx = 0;
    rst = 1'b1; s_tvalid = 1'b0; s_tdata = 8'h00;
    line_clear();
    fix_pos[0] = '0; fix_pos[1] = '0; fix_ok = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    add_row("", OC_NOT_RMC);
    add_row("$GPRM", OC_NOT_RMC);
    add_row("$GLRMC,1,A,4807.038,N,01131.000,E*00", OC_NOT_RMC);
    add_row("$GPRMC,1,A,4807.038,N,01131.000,E", OC_BAD_CSUM);
    add_row("$GPRMC,1,A,4807.038,N,01131.000,E*00", OC_BAD_CSUM);
    add_row("$GPRMC,123519,A,4807.038,N,01131.000,E*6A", OC_BAD_CSUM);
    long_line = "$GPRMC,1,A,4807.038,N";
    add_row(long_line, -1);
    foreach (dir_rows[i]) begin
      for (int j = 0; j < dir_rows[i].text.len(); j++) tx_bytes.push_back(dir_rows[i].text[j]);
      tx_bytes.push_back(8'h0a);
    end
    // expected outcomes of the table checked against the predictor as words go in
    foreach (dir_rows[i]) begin
      for (int j = 0; j < dir_rows[i].text.len(); j++) send_byte(dir_rows[i].text[j]);
      send_byte(8'h0a);
      if (dir_rows[i].outcome >= 0) begin
        want_code = dir_rows[i].outcome;
        if (fix_queue[$].outcome != want_code)
          report_mismatch("directed outcome", fix_queue[$].outcome, want_code);
      end
    end
    tx_bytes.delete();

    // checksummed directed sentences: every outcome and the numeric extremes
    add_sentence("$GPRMC,1,A,4807.03800,N", 1);
    add_sentence("$GPRMC,1,V,4807.038,N,01131.000,E", 1);
    add_sentence("$GNRMC,1,,4807.038,N,01131.000,E", 1);
    add_sentence("$GPRMC,1,A,,N,01131.000,E", 1);
    add_sentence("$GPRMC,1,A,4807.038,N,,E", 1);
    add_sentence("$GPRMC,1,A,4807.038,N,01131.000,E", 1);
    add_sentence("$GPRMC,1,A,9999999999.9999999,S,9999999999.99999,W", 1);
    add_sentence("$GNRMC,1,A,-0000.00001,S,+17959.999991,W,,,", 1);
    add_sentence("$GPRMC,1,A,-9000.0,N,-18000.0,S", 1);
    add_sentence("$GPRMC,1,A,.,N,x,E", 1);
    add_sentence("$GPRMC,1,A,12.3.4,W,5-6,N*,", 1);
    add_str("$GPRMC,1,A,1,N,2,E*zz\n");
    add_str({"$GPRMC,1,A,1,N,2,E*", hex2(body_xor("$GPRMC,1,A,1,N,2,E")), "00\n"});
    long_line = "$GPRMC,1,A,4807.038,N,01131.000,E*";
    long_line = {long_line, hex2(body_xor("$GPRMC,1,A,4807.038,N,01131.000,E"))};
    while (long_line.len() < 140) long_line = {long_line, "Z"};
    add_str({long_line, "\n"});
    tx_bytes.push_back(8'h00); tx_bytes.push_back(8'hff); tx_bytes.push_back(8'h0d);
    tx_bytes.push_back(8'h0a);
    send_all();

    // wait for all results, then a long receiver stall while the sender keeps going
    while (fix_queue.size() > 0) @(posedge clk);
    hold_rx = 1;
    repeat (2) @(posedge clk);
    hold_rx = 0;
    for (int i = 0; i < 10; i++) add_sentence(rand_rmc(), 1);
    send_all();

    // random part: mostly well formed sentences, some broken ones and noise
    while (lines_left_rand < RAND_LINES) begin
      case ($urandom_range(0, 9))
        0: add_noise_line();
        1: add_sentence(rand_rmc(), 0);
        default: add_sentence(rand_rmc(), 1);
      endcase
      lines_left_rand++;
      if (lines_left_rand % 5 == 0) begin
        send_all();
        // sender pause until the block has drained
        while (fix_queue.size() > 0) @(posedge clk);
      end
    end
    send_all();
    done_tx = 1;
  end

  // receiver: random back pressure plus one long hold-off
  initial begin
    int hold;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_rx) begin
        m_tready <= 1'b0;
        repeat (1500) @(posedge clk);
      end
      hold = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 50) : $urandom_range(0, 1);
      if ($urandom_range(0, 2) == 0) hold = 0;
      if (hold > 0) begin
        m_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    fix_rec_t w;
    if (!rst && m_tvalid && m_tready) begin
      if (fix_queue.size() == 0) begin
        report_mismatch("unexpected word", m_tdata[63:0], 0);
      end else begin
        w = fix_queue.pop_front();
        if (m_tdata[2:0] != w.outcome) report_mismatch("outcome", m_tdata[2:0], w.outcome);
        if (m_tdata[3] != w.fix_valid) report_mismatch("fix_valid", m_tdata[3], w.fix_valid);
        if (m_tdata[38:4] != w.lat_e7) report_mismatch("latitude_e7", m_tdata[38:4], w.lat_e7);
        if (m_tdata[73:39] != w.lon_e7)
          report_mismatch("longitude_e7", m_tdata[73:39], w.lon_e7);
      end
    end
  end

  // watchdog and end of run
  initial begin
    int idle;
    idle = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
      else idle++;
      if (done_tx && fix_queue.size() == 0) begin
        repeat (20) @(posedge clk);
        if (errors == 0 && fix_queue.size() == 0) $display("nmea_rmc_position_parser_test passed");
        else $display("nmea_rmc_position_parser_test failed");
        $finish;
      end
      if (idle >= STALL_MAX) begin
        $display("nmea_rmc_position_parser_test failed");
        $finish;
      end
    end
  end

endmodule
`default_nettype wire
